/* sv/mtt_pkg.sv */
// Shared types, constants and character classification functions for the tokenizer.
`timescale 1ns / 1ps

package mtt_pkg;

    localparam int CP_W = 21;
    localparam int DEFAULT_QUEUE_DEPTH = 4;

    // Result kinds.
    localparam logic [1:0] KIND_CHAR      = 2'd0;
    localparam logic [1:0] KIND_TOKEN_END = 2'd1;
    localparam logic [1:0] KIND_LINE_END  = 2'd2;

    // Slots of a command mask, in delivery order.
    localparam int SLOT_C0_PRE  = 0;
    localparam int SLOT_C0_CHR  = 1;
    localparam int SLOT_C0_POST = 2;
    localparam int SLOT_C1_PRE  = 3;
    localparam int SLOT_C1_CHR  = 4;
    localparam int SLOT_C1_POST = 5;
    localparam int SLOT_FIN_END = 6;
    localparam int SLOT_LINE    = 7;
    localparam int NUM_SLOTS    = 8;

    localparam logic [CP_W-1:0] CP_PERIOD = 21'h0002E;
    localparam logic [CP_W-1:0] CP_COMMA  = 21'h0002C;
    localparam logic [CP_W-1:0] CASE_OFFSET = 21'd32;

    // One command: which results to give and the two characters they may carry.
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [CP_W-1:0]      char0;
        logic [CP_W-1:0]      char1;
    } t_cmd;

    // Outcome of classifying one character.
    typedef struct packed {
        logic            pre_end;
        logic            chr_en;
        logic [CP_W-1:0] chr;
        logic            post_end;
        logic            open;
        logic            digit;
    } t_cls;

    function automatic logic is_decimal(input logic [CP_W-1:0] c);
        return (c >= 21'h30) && (c <= 21'h39);
    endfunction

    function automatic logic is_ideograph(input logic [CP_W-1:0] c);
        return ((c >= 21'h04E00) && (c <= 21'h09FFF)) ||
               ((c >= 21'h03400) && (c <= 21'h04DBF)) ||
               ((c >= 21'h20000) && (c <= 21'h2A6DF)) ||
               ((c >= 21'h2A700) && (c <= 21'h2EBEF)) ||
               ((c >= 21'h30000) && (c <= 21'h3134F));
    endfunction

    // Accented a/e and c-cedilla fold to their plain letters.
    function automatic logic [CP_W-1:0] flatten(input logic [CP_W-1:0] c);
        logic [CP_W-1:0] r;
        case (c)
            21'hE8, 21'hE9, 21'hEA, 21'hEB: r = 21'h65;
            21'hC8, 21'hC9, 21'hCA, 21'hCB: r = 21'h45;
            21'hE0, 21'hE1, 21'hE2, 21'hE4: r = 21'h61;
            21'hC0, 21'hC1, 21'hC2, 21'hC4: r = 21'h41;
            21'hE7: r = 21'h63;
            21'hC7: r = 21'h43;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic t_cls classify(input logic [CP_W-1:0] raw,
                                      input logic prev_digit,
                                      input logic tok_open,
                                      input logic next_digit);
        t_cls            r;
        logic [CP_W-1:0] c;
        logic            upper;
        logic            lower;
        logic            joined;
        c      = flatten(raw);
        upper  = (c >= 21'h41) && (c <= 21'h5A);
        lower  = (c >= 21'h61) && (c <= 21'h7A);
        joined = prev_digit && next_digit;
        r          = '0;
        r.chr      = c;
        r.digit    = is_decimal(c);
        if (upper || lower || is_decimal(c)) begin
            r.chr_en = 1'b1;
            r.open   = 1'b1;
            if (upper) begin
                r.chr = c + CASE_OFFSET;
            end
        end else if (c == CP_PERIOD) begin
            if (joined) begin
                r.chr_en = 1'b1;
                r.open   = 1'b1;
            end else begin
                r.pre_end = tok_open;
            end
        end else if (c == CP_COMMA) begin
            if (joined) begin
                r.open = tok_open;
            end else begin
                r.pre_end = tok_open;
            end
        end else if (is_ideograph(c)) begin
            r.pre_end  = tok_open;
            r.chr_en   = 1'b1;
            r.post_end = 1'b1;
        end else begin
            r.pre_end = tok_open;
        end
        return r;
    endfunction

endpackage

/* sv/mtt_front.sv */
// Front end: takes input beats, runs the lookahead classification and builds commands.
`timescale 1ns / 1ps

module mtt_front
    import mtt_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [CP_W-1:0] i_codepoint,
    input  logic            i_char_valid,
    input  logic            i_line_end,
    input  logic            i_queue_full,
    output logic            o_push,
    output t_cmd            o_cmd
);

    logic [CP_W-1:0] r_held;
    logic            r_held_valid;
    logic            r_prev_digit;
    logic            r_tok_open;

    logic [CP_W-1:0] n_held;
    logic            n_held_valid;
    logic            n_prev_digit;
    logic            n_tok_open;

    t_cls            cls0;
    t_cls            cls1;
    logic            en0;
    logic            en1;
    logic            tok_a;
    logic            prev_a;
    logic            tok_b;
    logic [CP_W-1:0] held_b;
    logic            held_valid_b;
    logic            accept;

    always_comb begin
        en0    = i_char_valid && r_held_valid;
        cls0   = classify(r_held, r_prev_digit, r_tok_open, is_decimal(i_codepoint));
        tok_a  = en0 ? cls0.open  : r_tok_open;
        prev_a = en0 ? cls0.digit : r_prev_digit;

        held_b       = i_char_valid ? i_codepoint : r_held;
        held_valid_b = i_char_valid || r_held_valid;

        // At a line end the last held character sees no lookahead.
        en1   = i_line_end && held_valid_b;
        cls1  = classify(held_b, prev_a, tok_a, 1'b0);
        tok_b = en1 ? cls1.open : tok_a;

        o_cmd                     = '0;
        o_cmd.char0               = cls0.chr;
        o_cmd.char1               = cls1.chr;
        o_cmd.mask[SLOT_C0_PRE]   = en0 && cls0.pre_end;
        o_cmd.mask[SLOT_C0_CHR]   = en0 && cls0.chr_en;
        o_cmd.mask[SLOT_C0_POST]  = en0 && cls0.post_end;
        o_cmd.mask[SLOT_C1_PRE]   = en1 && cls1.pre_end;
        o_cmd.mask[SLOT_C1_CHR]   = en1 && cls1.chr_en;
        o_cmd.mask[SLOT_C1_POST]  = en1 && cls1.post_end;
        o_cmd.mask[SLOT_FIN_END]  = i_line_end && tok_b;
        o_cmd.mask[SLOT_LINE]     = i_line_end;

        accept = i_in_valid && !i_queue_full;
        o_push = accept && (o_cmd.mask != '0);

        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_prev_digit = r_prev_digit;
        n_tok_open   = r_tok_open;
        if (accept) begin
            if (i_line_end) begin
                n_held       = '0;
                n_held_valid = 1'b0;
                n_prev_digit = 1'b0;
                n_tok_open   = 1'b0;
            end else begin
                n_held       = held_b;
                n_held_valid = held_valid_b;
                n_prev_digit = prev_a;
                n_tok_open   = tok_a;
            end
        end
    end

    assign o_in_stall = i_queue_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_prev_digit <= 1'b0;
            r_tok_open   <= 1'b0;
        end else begin
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_prev_digit <= n_prev_digit;
            r_tok_open   <= n_tok_open;
        end
    end

endmodule

/* sv/mtt_queue.sv */
// Small register queue of commands between the front and back ends.
`timescale 1ns / 1ps

module mtt_queue
    import mtt_pkg::*;
#(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_cmd o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == FULL_CNT);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/mtt_back.sv */
// Back end: walks each command's mask and delivers one result beat per cycle while the output is not stalled.
`timescale 1ns / 1ps

module mtt_back
    import mtt_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  t_cmd            i_q_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [1:0]      o_kind,
    output logic [CP_W-1:0] o_token_char,
    output logic            o_last
);

    logic [NUM_SLOTS-1:0] r_mask;
    logic [CP_W-1:0]      r_char0;
    logic [CP_W-1:0]      r_char1;
    logic                 r_out_valid;
    logic [1:0]           r_kind;
    logic [CP_W-1:0]      r_token_char;
    logic                 r_last;

    logic                 load_ok;
    logic                 use_q;
    logic [NUM_SLOTS-1:0] src;
    logic [NUM_SLOTS-1:0] sel;
    logic [NUM_SLOTS-1:0] rem;
    logic [CP_W-1:0]      src_char0;
    logic [CP_W-1:0]      src_char1;
    logic [1:0]           n_kind;
    logic [CP_W-1:0]      n_token_char;

    always_comb begin
        load_ok   = !r_out_valid || !i_out_stall;
        use_q     = (r_mask == '0);
        src       = use_q ? (i_q_valid ? i_q_head.mask : '0) : r_mask;
        src_char0 = use_q ? i_q_head.char0 : r_char0;
        src_char1 = use_q ? i_q_head.char1 : r_char1;
        // Lowest pending slot goes out first.
        sel       = src & (~src + 1'b1);
        rem       = src & ~sel;

        n_kind       = KIND_TOKEN_END;
        n_token_char = '0;
        if (sel[SLOT_C0_CHR]) begin
            n_kind       = KIND_CHAR;
            n_token_char = src_char0;
        end else if (sel[SLOT_C1_CHR]) begin
            n_kind       = KIND_CHAR;
            n_token_char = src_char1;
        end else if (sel[SLOT_LINE]) begin
            n_kind = KIND_LINE_END;
        end

        o_pop = load_ok && use_q && i_q_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else if (load_ok) begin
            r_out_valid <= (src != '0);
            r_mask      <= rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            r_kind       <= n_kind;
            r_token_char <= n_token_char;
            r_last       <= (rem == '0);
            if (use_q) begin
                r_char0 <= i_q_head.char0;
                r_char1 <= i_q_head.char1;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_token_char = r_token_char;
    assign o_last       = r_last;

endmodule

/* sv/mixed_text_tokenizer_top.sv */
// Top level of the mixed text tokenizer: front end, command queue and back end.
`timescale 1ns / 1ps

// The tokenizer takes one decoded codepoint beat per cycle while input stall is
// low and turns it into token characters, end-of-token marks and end-of-line
// marks. One character is held back for one character of lookahead, so the
// results of a character appear when the next character (or the line end)
// arrives. The front end classifies each input beat in the cycle it is accepted
// and turns it into a command of up to six results; a command queue of
// QUEUE_DEPTH entries carries those commands to the back end, which delivers
// exactly one result beat per cycle, while the output is not stalled, from a
// registered output stage; beats that cause one result or none then flow at
// one beat per cycle. Input stall rises only when the command queue is full,
// which happens when bursts from ideographs and line ends outpace the output
// or the output is stalled. The last flag marks the final result of each input
// beat; a beat that carries neither a character nor a line end gives nothing.
// Codepoints above the Unicode range are treated as delimiters.

module mixed_text_tokenizer_top
    import mtt_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [CP_W-1:0] i_codepoint,
    input  logic            i_char_valid,
    input  logic            i_line_end,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [1:0]      o_kind,
    output logic [CP_W-1:0] o_token_char,
    output logic            o_last
);

    logic q_push;
    logic q_pop;
    logic q_valid;
    logic q_full;
    t_cmd front_cmd;
    t_cmd q_head;

    // Front end: lookahead classification and token state.
    mtt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_codepoint  (i_codepoint),
        .i_char_valid (i_char_valid),
        .i_line_end   (i_line_end),
        .i_queue_full (q_full),
        .o_push       (q_push),
        .o_cmd        (front_cmd)
    );

    // Decouples the classification rate from the output rate.
    mtt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    // Back end: one result beat per cycle while the output is not stalled.
    mtt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_head     (q_head),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_token_char (o_token_char),
        .o_last       (o_last)
    );

`ifndef SYNTHESIS
    // The front end must never push into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    // An end of line is always the final result of its input beat.
    a_line_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_LINE_END)) |-> o_last)
        else $error("end of line without last flag");

    // Only token characters carry a codepoint.
    a_mark_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind != KIND_CHAR)) |-> (o_token_char == '0))
        else $error("mark beat carries a nonzero character");

    // A beat with no results pushes nothing: a push carries at least one result.
    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (front_cmd.mask != '0))
        else $error("empty command pushed");
`endif

endmodule
